[rtl/rpwm_pkg.sv]
package rpwm_pkg;

    // Register file layout
    localparam int CFG_W       = 20;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_MIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_MIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CAPTURE = 3'd4;

    localparam logic [CFG_W-1:0] MIN_LOW_RST     = 20'd80;
    localparam logic [CFG_W-1:0] SYNC_MIN_RST    = 20'd5000;
    localparam logic [CFG_W-1:0] LONG_MIN_RST    = 20'd600;
    localparam logic [CFG_W-1:0] QUIET_RST       = 20'd20000;
    localparam logic [CFG_W-1:0] MAX_CAPTURE_RST = 20'd500000;

    // Frame format
    localparam int FRAME_SYMBOLS = 40;
    localparam int TALLY_W       = 6;
    localparam int FP_COUNT      = 9;
    localparam int CODE_W        = 4;

    localparam logic [TALLY_W-1:0] FRAME_TALLY = TALLY_W'(FRAME_SYMBOLS);

    // Fingerprints: long symbol = 1, first symbol in the MSB
    localparam logic [23:0] FP_PREFIX = 24'b100110000001001001000100;

    localparam logic [FRAME_SYMBOLS-1:0] FP_ROM [FP_COUNT] = '{
        {FP_PREFIX, 16'b1010101001010101},  // power
        {FP_PREFIX, 16'b1101000000101111},  // forward
        {FP_PREFIX, 16'b1110110000010011},  // mist
        {FP_PREFIX, 16'b1101100000100111},  // breeze
        {FP_PREFIX, 16'b1010011001011001},  // oscillate
        {FP_PREFIX, 16'b1011010101001010},  // fan minus
        {FP_PREFIX, 16'b1001011101101000},  // fan plus
        {FP_PREFIX, 16'b1110001100011100},  // cw jog
        {FP_PREFIX, 16'b1100101100110100}   // ccw jog
    };

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

    // Event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic                     frame_valid;  // a complete frame closed by a sync
        logic [FRAME_SYMBOLS-1:0] frame_bits;
        logic                     capture_end;  // capture finished on this sample
        logic                     overflow;     // capture finished on pulse overflow
    } frame_evt_t;

endpackage

[rtl/rpwm_front.sv]
module rpwm_front #(
    parameter int PULSE_CAPACITY = 128,
    parameter int TIMER_BITS     = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                rf_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rpwm_pkg::CFG_W-1:0]          cfg_data,
    output logic                                evt_push,
    output rpwm_pkg::frame_evt_t                evt
);
    import rpwm_pkg::*;

    localparam int CNT_W = $clog2(PULSE_CAPACITY + 1);
    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [CNT_W-1:0] CAP = CNT_W'(PULSE_CAPACITY);

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == TMAX) ? v : v + TIMER_BITS'(1);
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] min_low_reg, sync_min_reg, long_min_reg, quiet_reg, max_cap_reg;

    // Line and capture state
    logic                     prior_reg, prior_next;
    logic                     low_open_reg, low_open_next;
    logic [TIMER_BITS-1:0]    low_len_reg, low_len_next;
    logic                     capt_reg, capt_next;
    logic [CNT_W-1:0]         pulses_reg, pulses_next;
    logic                     exceeded_reg, exceeded_next;
    logic [TIMER_BITS-1:0]    since_first_reg, since_first_next;
    logic [TIMER_BITS-1:0]    since_last_reg, since_last_next;
    logic                     sync_seen_reg, sync_seen_next;
    logic [FRAME_SYMBOLS-1:0] bits_reg, bits_next;
    logic [TALLY_W-1:0]       tally_reg, tally_next;
    logic                     too_long_reg, too_long_next;

    logic in_fire;
    logic frame_ev, cap_end;

    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_low_reg  <= MIN_LOW_RST;
            sync_min_reg <= SYNC_MIN_RST;
            long_min_reg <= LONG_MIN_RST;
            quiet_reg    <= QUIET_RST;
            max_cap_reg  <= MAX_CAPTURE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_LOW:     min_low_reg  <= cfg_data;
                REG_SYNC_MIN:    sync_min_reg <= cfg_data;
                REG_LONG_MIN:    long_min_reg <= cfg_data;
                REG_QUIET:       quiet_reg    <= cfg_data;
                REG_MAX_CAPTURE: max_cap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-sample update: timers, edge handling, framing, end test
    always_comb
    begin
        logic                  fall, rise, pulse_ok, is_sync, is_long;
        logic [TIMER_BITS-1:0] width;

        prior_next       = rf_level;
        low_open_next    = low_open_reg;
        low_len_next     = low_open_reg ? sat_inc(low_len_reg) : low_len_reg;
        capt_next        = capt_reg;
        pulses_next      = pulses_reg;
        exceeded_next    = exceeded_reg;
        since_first_next = capt_reg ? sat_inc(since_first_reg) : since_first_reg;
        since_last_next  = capt_reg ? sat_inc(since_last_reg) : since_last_reg;
        sync_seen_next   = sync_seen_reg;
        bits_next        = bits_reg;
        tally_next       = tally_reg;
        too_long_next    = too_long_reg;
        frame_ev         = 1'b0;
        pulse_ok         = 1'b0;

        fall  = !rf_level && prior_reg;
        rise  = rf_level && !prior_reg && low_open_reg;
        width = low_len_next;

        if (fall)
        begin
            low_open_next = 1'b1;
            low_len_next  = '0;
        end
        else if (rise)
        begin
            low_open_next = 1'b0;
            pulse_ok      = CMP_W'(width) >= CMP_W'(min_low_reg);
        end

        is_sync = CMP_W'(width) >= CMP_W'(sync_min_reg);
        is_long = CMP_W'(width) >= CMP_W'(long_min_reg);

        if (pulse_ok)
        begin
            if (!capt_reg)
            begin
                capt_next        = 1'b1;
                since_first_next = width;
            end
            since_last_next = '0;
            if (pulses_reg >= CAP)
            begin
                exceeded_next = 1'b1;
            end
            else
            begin
                pulses_next = pulses_reg + CNT_W'(1);
                if (is_sync)
                begin
                    frame_ev       = sync_seen_reg && !too_long_reg && (tally_reg == FRAME_TALLY);
                    sync_seen_next = 1'b1;
                    bits_next      = '0;
                    tally_next     = '0;
                    too_long_next  = 1'b0;
                end
                else if (sync_seen_reg)
                begin
                    if (tally_reg >= FRAME_TALLY)
                    begin
                        too_long_next = 1'b1;
                    end
                    else
                    begin
                        bits_next  = {bits_reg[FRAME_SYMBOLS-2:0], is_long};
                        tally_next = tally_reg + TALLY_W'(1);
                    end
                end
            end
        end

        cap_end = capt_next && (exceeded_next
                  || CMP_W'(since_last_next) >= CMP_W'(quiet_reg)
                  || CMP_W'(since_first_next) >= CMP_W'(max_cap_reg));

        evt.frame_valid = frame_ev;
        evt.frame_bits  = bits_reg;
        evt.capture_end = cap_end;
        evt.overflow    = exceeded_next;

        // End of capture drops all capture state, including an open low pulse
        if (cap_end)
        begin
            capt_next        = 1'b0;
            pulses_next      = '0;
            exceeded_next    = 1'b0;
            since_first_next = '0;
            since_last_next  = '0;
            sync_seen_next   = 1'b0;
            bits_next        = '0;
            tally_next       = '0;
            too_long_next    = 1'b0;
            low_open_next    = 1'b0;
            low_len_next     = '0;
        end
    end

    assign evt_push = in_fire && (frame_ev || cap_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg       <= 1'b1;
            low_open_reg    <= 1'b0;
            low_len_reg     <= '0;
            capt_reg        <= 1'b0;
            pulses_reg      <= '0;
            exceeded_reg    <= 1'b0;
            since_first_reg <= '0;
            since_last_reg  <= '0;
            sync_seen_reg   <= 1'b0;
            bits_reg        <= '0;
            tally_reg       <= '0;
            too_long_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            prior_reg       <= prior_next;
            low_open_reg    <= low_open_next;
            low_len_reg     <= low_len_next;
            capt_reg        <= capt_next;
            pulses_reg      <= pulses_next;
            exceeded_reg    <= exceeded_next;
            since_first_reg <= since_first_next;
            since_last_reg  <= since_last_next;
            sync_seen_reg   <= sync_seen_next;
            bits_reg        <= bits_next;
            tally_reg       <= tally_next;
            too_long_reg    <= too_long_next;
        end
    end

    // Idle capture holds no pulses and no overflow
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !capt_reg |-> (pulses_reg == '0 && !exceeded_reg))
        else $error("pulse state left over outside a capture");

    // Overflow can only be flagged with the pulse store full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        exceeded_reg |-> (pulses_reg == CAP))
        else $error("overflow flagged below capacity");

endmodule

[rtl/rpwm_queue.sv]
module rpwm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpwm_pkg::frame_evt_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output rpwm_pkg::frame_evt_t head_data
);
    import rpwm_pkg::*;

    frame_evt_t        slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("event queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("event queue read while empty");

endmodule

[rtl/rpwm_back.sv]
module rpwm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  rpwm_pkg::frame_evt_t         head_data,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rpwm_pkg::CODE_W-1:0]  remote_code,
    output logic                         overflowed
);
    import rpwm_pkg::*;

    logic [CODE_W-1:0] match_reg, match_next;
    logic [CODE_W-1:0] hit;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              ovf_reg;

    // Accept the next event whenever the output slot is free or draining
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Fingerprint compare, lowest entry wins
    always_comb
    begin
        hit = CODE_NONE;
        for (int e = FP_COUNT - 1; e >= 0; e--)
        begin
            if (head_data.frame_bits == FP_ROM[e])
            begin
                hit = CODE_W'(e + 1);
            end
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (head_data.frame_valid && match_reg == CODE_NONE)
        begin
            match_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= CODE_NONE;
            out_valid_reg <= 1'b0;
            code_reg      <= CODE_NONE;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (pop && head_data.capture_end)
            begin
                // New result replaces a drained or empty output slot
                match_reg     <= CODE_NONE;
                out_valid_reg <= 1'b1;
                code_reg      <= head_data.overflow ? CODE_NONE : match_next;
                ovf_reg       <= head_data.overflow;
            end
            else
            begin
                if (out_valid_reg && !out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (pop)
                begin
                    match_reg <= match_next;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign remote_code = code_reg;
    assign overflowed  = ovf_reg;

    a_ovf_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (code_reg == CODE_NONE))
        else $error("overflow result carries a command");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= CODE_W'(FP_COUNT))
        else $error("match code beyond fingerprint table");

endmodule

[rtl/rf_pulse_width_code_matcher_top.sv]
// RF pulse-width code matcher. Takes one receiver line sample per clock
// (one item per cycle while in_stall is low), times low pulses, frames
// 40-symbol words between sync pulses, matches them against nine
// fingerprints and delivers one result (command code 0..9, overflow flag)
// per finished capture. The sample input stalls only when the four-entry
// event queue between the pulse front end and the matcher is full, which
// takes a stalled result output. The result of the sample that ends the
// capture is registered in the event queue and then in the output
// register. Configuration is five 20-bit registers, written by index with
// cfg_ready always high.
module rf_pulse_width_code_matcher_top #(
    parameter int PULSE_CAPACITY = 128,
    parameter int TIMER_BITS     = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                rf_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rpwm_pkg::CODE_W-1:0]         remote_code,
    output logic                                overflowed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rpwm_pkg::CFG_W-1:0]          cfg_data
);
    import rpwm_pkg::*;

    logic       evt_push, q_full, q_pop, q_valid;
    frame_evt_t evt, q_head;

    assign in_stall = q_full;

    rpwm_front #(
        .PULSE_CAPACITY (PULSE_CAPACITY),
        .TIMER_BITS     (TIMER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (q_full),
        .rf_level  (rf_level),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_push  (evt_push),
        .evt       (evt)
    );

    rpwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (evt_push),
        .push_data  (evt),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    rpwm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_valid),
        .head_data   (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .remote_code (remote_code),
        .overflowed  (overflowed)
    );

endmodule

[tb/tb_rf_pulse_width_code_matcher_top.sv]
typedef struct packed {
    logic [rpwm_pkg::CODE_W-1:0] code;
    logic                        ovf;
} remote_result_t;

// Tracks the line decoder state per accepted sample and holds the results
// that finished captures must produce.
class capture_scoreboard #(int PULSE_LIMIT = 128);
    localparam int FRAME_LEN = 40;
    localparam int FP_NUM    = 9;

    // register copies
    logic [19:0] min_low, sync_min, long_min, quiet, max_cap;

    // pulse timing and capture state
    bit          prior_level, low_open, capturing, cap_full, sync_seen, frame_long;
    logic [19:0] low_len, since_first, since_last;
    int          pulse_count, sym_count;
    logic [39:0] sym_bits;
    logic [3:0]  matched;

    logic [39:0]    fp_table [FP_NUM];
    remote_result_t pending_results [$];
    int             fail_count;

    function new();
        string txt [FP_NUM];
        txt = '{"LSSLLSSSSSSLSSLSSLSSSLSSLSLSLSLSSLSLSLSL",
                "LSSLLSSSSSSLSSLSSLSSSLSSLLSLSSSSSSLSLLLL",
                "LSSLLSSSSSSLSSLSSLSSSLSSLLLSLLSSSSSLSSLL",
                "LSSLLSSSSSSLSSLSSLSSSLSSLLSLLSSSSSLSSLLL",
                "LSSLLSSSSSSLSSLSSLSSSLSSLSLSSLLSSLSLLSSL",
                "LSSLLSSSSSSLSSLSSLSSSLSSLSLLSLSLSLSSLSLS",
                "LSSLLSSSSSSLSSLSSLSSSLSSLSSLSLLLSLLSLSSS",
                "LSSLLSSSSSSLSSLSSLSSSLSSLLLSSSLLSSSLLLSS",
                "LSSLLSSSSSSLSSLSSLSSSLSSLLSSLSLLSSLLSLSS"};
        // first symbol lands in the MSB, long = 1
        for (int e = 0; e < FP_NUM; e++)
        begin
            fp_table[e] = '0;
            for (int k = 0; k < FRAME_LEN; k++)
                fp_table[e] = {fp_table[e][38:0], txt[e][k] == "L"};
        end
        min_low     = 20'd80;
        sync_min    = 20'd5000;
        long_min    = 20'd600;
        quiet       = 20'd20000;
        max_cap     = 20'd500000;
        prior_level = 1'b1;
        low_open    = 1'b0;
        low_len     = '0;
        fail_count  = 0;
        clear_capture();
    endfunction

    function void set_reg(logic [rpwm_pkg::CFG_INDEX_W-1:0] idx, logic [19:0] val);
        case (idx)
            rpwm_pkg::REG_MIN_LOW:     min_low  = val;
            rpwm_pkg::REG_SYNC_MIN:    sync_min = val;
            rpwm_pkg::REG_LONG_MIN:    long_min = val;
            rpwm_pkg::REG_QUIET:       quiet    = val;
            rpwm_pkg::REG_MAX_CAPTURE: max_cap  = val;
            default: ;
        endcase
    endfunction

    // saturating timer step
    function logic [19:0] bump(logic [19:0] v);
        return (&v) ? v : v + 20'd1;
    endfunction

    function void clear_capture();
        capturing   = 1'b0;
        pulse_count = 0;
        cap_full    = 1'b0;
        since_first = '0;
        since_last  = '0;
        sync_seen   = 1'b0;
        sym_bits    = '0;
        sym_count   = 0;
        frame_long  = 1'b0;
        matched     = rpwm_pkg::CODE_NONE;
    endfunction

    // sync closes a frame; symbols shift in behind the first sync
    function void frame_pulse(logic [19:0] w);
        if (w >= sync_min)
        begin
            if (sync_seen && !frame_long && sym_count == FRAME_LEN &&
                matched == rpwm_pkg::CODE_NONE)
            begin
                for (int e = 0; e < FP_NUM; e++)
                begin
                    if (sym_bits == fp_table[e])
                    begin
                        matched = 4'(e + 1);
                        break;
                    end
                end
            end
            sync_seen  = 1'b1;
            sym_bits   = '0;
            sym_count  = 0;
            frame_long = 1'b0;
            return;
        end
        if (!sync_seen)
            return;
        if (sym_count >= FRAME_LEN)
        begin
            frame_long = 1'b1;
            return;
        end
        sym_bits  = {sym_bits[38:0], w >= long_min};
        sym_count = sym_count + 1;
    endfunction

    function void accept_pulse(logic [19:0] w);
        if (!capturing)
        begin
            capturing   = 1'b1;
            since_first = w;
        end
        since_last = '0;
        if (pulse_count >= PULSE_LIMIT)
        begin
            cap_full = 1'b1;
            return;
        end
        pulse_count = pulse_count + 1;
        frame_pulse(w);
    endfunction

    // one accepted line sample: timers, then edges, then end of capture
    function void take_sample(bit lvl);
        remote_result_t r;
        if (capturing)
        begin
            since_first = bump(since_first);
            since_last  = bump(since_last);
        end
        if (low_open)
            low_len = bump(low_len);
        if (!lvl && prior_level)
        begin
            low_open = 1'b1;
            low_len  = '0;
        end
        else if (lvl && !prior_level && low_open)
        begin
            low_open = 1'b0;
            if (low_len >= min_low)
                accept_pulse(low_len);
        end
        prior_level = lvl;
        if (capturing && (cap_full || since_last >= quiet || since_first >= max_cap))
        begin
            r.code = cap_full ? rpwm_pkg::CODE_NONE : matched;
            r.ovf  = cap_full;
            pending_results.push_back(r);
            clear_capture();
            low_open = 1'b0;
            low_len  = '0;
        end
    endfunction

    function void note_failure(string what);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
            $display("mismatch: %s", what);
    endfunction

    function void check_result(logic [3:0] code, logic ovf);
        remote_result_t r;
        if (pending_results.size() == 0)
        begin
            note_failure($sformatf("result code=%0d overflowed=%0d with no capture pending",
                                   code, ovf));
            return;
        end
        r = pending_results.pop_front();
        if (code !== r.code)
            note_failure($sformatf("remote_code expected %0d got %0d", r.code, code));
        if (ovf !== r.ovf)
            note_failure($sformatf("overflowed expected %0d got %0d", r.ovf, ovf));
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction
endclass

module tb_rf_pulse_width_code_matcher_top;

    localparam int PULSE_CAPACITY = 128;
    localparam int TIMER_BITS     = 20;
    localparam logic [rpwm_pkg::CFG_INDEX_W-1:0] REG_BEYOND_LIST = 3'd7;
    localparam logic [19:0] CFG_MAX = 20'hFFFFF;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid;
    logic                               in_stall;
    logic                               rf_level;
    logic                               out_valid;
    logic                               out_stall;
    logic [rpwm_pkg::CODE_W-1:0]        remote_code;
    logic                               overflowed;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rpwm_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [rpwm_pkg::CFG_W-1:0]         cfg_data;

    capture_scoreboard #(PULSE_CAPACITY) sb;

    bit sender_idle = 1'b0;
    bit sink_idle   = 1'b0;
    int hold_cycles = 0;

    always #6 clk = ~clk;

    rf_pulse_width_code_matcher_top #(
        .PULSE_CAPACITY (PULSE_CAPACITY),
        .TIMER_BITS     (TIMER_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rf_level    (rf_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .remote_code (remote_code),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // one line sample per item, optional gap ahead of it
    task automatic send_level(input bit lvl);
        int gap_n;
        gap_n = sender_idle ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap_n > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_n) @(negedge clk);
        end
        in_valid <= 1'b1;
        rf_level <= lvl;
        do @(posedge clk); while (in_stall === 1'b1);
        sb.take_sample(lvl);
    endtask

    task automatic send_run(input bit lvl, input int n);
        repeat (n) send_level(lvl);
    endtask

    // low pulse of w ticks followed by a short high
    task automatic send_pulse(input int w);
        send_run(1'b0, w);
        send_run(1'b1, $urandom_range(1, 2));
    endtask

    function automatic int short_width();
        return $urandom_range(int'(sb.long_min) - 1, int'(sb.min_low));
    endfunction

    function automatic int long_width();
        return $urandom_range(int'(sb.sync_min) - 1, int'(sb.long_min));
    endfunction

    task automatic send_sync();
        send_pulse($urandom_range(int'(sb.sync_min) + 2, int'(sb.sync_min)));
    endtask

    // symbols MSB first; past 40 the extra symbols are random
    task automatic send_symbols(input logic [39:0] word, input int n_sym, input int glitch_pct);
        bit b;
        for (int k = 0; k < n_sym; k++)
        begin
            if (glitch_pct > 0 && int'(sb.min_low) > 1 && $urandom_range(0, 99) < glitch_pct)
                send_pulse($urandom_range(int'(sb.min_low) - 1, 1));
            b = (k < 40) ? word[39 - k] : ($urandom_range(0, 1) != 0);
            send_pulse(b ? long_width() : short_width());
        end
    endtask

    // line stays quiet long enough to end the capture, optionally held low
    task automatic close_capture(input bit open_low);
        if (open_low)
            send_run(1'b0, int'(sb.quiet) + 2);
        send_run(1'b1, int'(sb.quiet) + 2);
    endtask

    // end any open capture, drop valid and wait for every result
    task automatic settle();
        int n;
        n = 0;
        while (sb.capturing && n < 64)
        begin
            send_level(1'b1);
            n = n + 1;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rpwm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [19:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [19:0] lo, input logic [19:0] sy,
                             input logic [19:0] lg, input logic [19:0] qt,
                             input logic [19:0] mc);
        write_reg(rpwm_pkg::REG_MIN_LOW, lo);
        write_reg(rpwm_pkg::REG_SYNC_MIN, sy);
        write_reg(rpwm_pkg::REG_LONG_MIN, lg);
        write_reg(rpwm_pkg::REG_QUIET, qt);
        write_reg(rpwm_pkg::REG_MAX_CAPTURE, mc);
    endtask

    // result side: per-item stall, long hold-off on request
    initial
    begin
        int stall_n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                stall_n = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall_n = sink_idle ? $urandom_range(0, 9) : 0;
            if (stall_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(remote_code, overflowed);
        end
    end

    // stimulus
    initial
    begin
        sb = new();
        in_valid  = 1'b0;
        rf_level  = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset thresholds: a glitch, then one symbol that opens a capture
        sender_idle = 1'b0;
        sink_idle   = 1'b1;
        send_run(1'b1, 3);
        send_run(1'b0, 50);
        send_run(1'b1, 3);
        send_run(1'b0, 100);
        send_run(1'b1, 3);
        @(negedge clk);
        in_valid <= 1'b0;

        // short pulses so that a frame fits in about a hundred samples;
        // the capture left open above ends on the new quiet time
        load_regs(20'd1, 20'd3, 20'd2, 20'd10, 20'd1000);
        sender_idle = 1'b1;
        close_capture(1'b0);

        // stray symbols ahead of the first sync, then a fingerprint
        send_pulse(long_width());
        send_pulse(short_width());
        send_sync();
        send_symbols(sb.fp_table[0], 40, 0);
        send_sync();
        close_capture(1'b0);

        // capture ends while the line is still low
        send_sync();
        send_symbols(sb.fp_table[8], 40, 0);
        send_sync();
        close_capture(1'b1);

        // overlong and short frames never match
        send_sync();
        send_symbols(sb.fp_table[2], 41, 0);
        send_sync();
        send_symbols(sb.fp_table[2], 39, 0);
        send_sync();
        close_capture(1'b0);

        // first matching frame wins over later ones
        send_sync();
        send_symbols(sb.fp_table[4] ^ 40'd1, 40, 0);
        send_sync();
        send_symbols(sb.fp_table[6], 40, 0);
        send_sync();
        send_symbols(sb.fp_table[1], 40, 0);
        send_sync();
        close_capture(1'b0);

        // pulse overflow
        send_sync();
        repeat (PULSE_CAPACITY + 2) send_pulse(short_width());
        close_capture(1'b0);
        settle();

        // zero thresholds: every pulse is a sync that ends its capture;
        // the receiver holds off for a long stretch so the block fills up
        load_regs(20'd0, 20'd0, 20'd0, 20'd0, CFG_MAX);
        write_reg(REG_BEYOND_LIST, 20'($urandom));
        sender_idle = 1'b0;
        sink_idle   = 1'b1;
        hold_cycles = 300;
        repeat (150) send_level($urandom_range(0, 1) != 0);
        settle();

        // top thresholds with a one-tick capture limit
        sender_idle = 1'b1;
        load_regs(20'd1, CFG_MAX, CFG_MAX, CFG_MAX, 20'd1);
        repeat (60) send_level($urandom_range(0, 1) != 0);
        settle();

        // nothing passes the glitch filter
        load_regs(CFG_MAX, 20'd0, 20'd0, 20'd1, 20'd0);
        repeat (40) send_level($urandom_range(0, 1) != 0);
        settle();

        repeat (20) @(negedge clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #36_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/rpwm_pkg.sv
rtl/rpwm_front.sv
rtl/rpwm_queue.sv
rtl/rpwm_back.sv
rtl/rf_pulse_width_code_matcher_top.sv
tb/tb_rf_pulse_width_code_matcher_top.sv
